### rtl/core/abtt_pkg.sv
`default_nettype none

package abtt_pkg;

	localparam int NODE_COUNT_DEF = 15;
	localparam int RESULT_CAP     = 15;
	localparam int CNT_W          = $clog2(RESULT_CAP + 1);

	typedef enum logic [1:0] {
		OP_ROOT     = 2'd0,
		OP_LEFT     = 2'd1,
		OP_RIGHT    = 2'd2,
		OP_TRAVERSE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ORD_IN   = 2'd0,
		ORD_PRE  = 2'd1,
		ORD_POST = 2'd2
	} ord_t;

	typedef enum logic [2:0] {
		ST_WRITTEN      = 3'd0,
		ST_ROOT_EXISTS  = 3'd1,
		ST_PARENT_EMPTY = 3'd2,
		ST_CHILD_RANGE  = 3'd3,
		ST_NODE         = 3'd4,
		ST_EMPTY        = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SET_CHK,
		S_WALK_CHK,
		S_WALK_RET,
		S_FLUSH
	} state_t;

	typedef struct packed {
		logic clear;
		logic push;
		logic pop;
		logic mark;
	} stk_ctl_t;

	typedef struct packed {
		logic empty;
		logic single;
	} stk_sts_t;

	function automatic logic is_letter(input logic [7:0] b);
		return ((b >= 8'h41) && (b <= 8'h5a)) || ((b >= 8'h61) && (b <= 8'h7a));
	endfunction

endpackage

`default_nettype wire

### rtl/core/abtt_store.sv
`default_nettype none

module abtt_store import abtt_pkg::*; #(
	parameter int DEPTH = NODE_COUNT_DEF,
	parameter int AW    = $clog2(NODE_COUNT_DEF)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [7:0]    wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [7:0]    rdata
);

	logic [7:0]       mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [7:0]       rd_q;
	logic             hit_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= mem[raddr];
	end

	// slots never written read as empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			hit_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			hit_q <= vld_q[raddr];
		end
	end

	assign rdata = hit_q ? rd_q : 8'd0;

endmodule

`default_nettype wire

### rtl/core/abtt_stack.sv
`default_nettype none

module abtt_stack import abtt_pkg::*; #(
	parameter int DEPTH = 4,
	parameter int IW    = 5
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire stk_ctl_t      ctl,
	input  wire logic [IW-1:0] push_idx,
	input  wire logic [7:0]    push_val,
	output logic      [IW-1:0] top_idx,
	output logic      [7:0]    top_val,
	output logic               top_right,
	output stk_sts_t           sts
);

	localparam int PW = $clog2(DEPTH + 1);
	localparam int SW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [IW-1:0] idx_q   [DEPTH];
	logic [7:0]    val_q   [DEPTH];
	logic          right_q [DEPTH];
	logic [PW-1:0] ptr_q;
	logic [PW-1:0] top_p;

	assign top_p = ptr_q - PW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
		end else if (ctl.clear) begin
			ptr_q <= '0;
		end else if (ctl.push) begin
			ptr_q <= ptr_q + PW'(1);
		end else if (ctl.pop) begin
			ptr_q <= top_p;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			idx_q[ptr_q[SW-1:0]]   <= push_idx;
			val_q[ptr_q[SW-1:0]]   <= push_val;
			right_q[ptr_q[SW-1:0]] <= 1'b0;
		end else if (ctl.mark) begin
			right_q[top_p[SW-1:0]] <= 1'b1;
		end
	end

	assign top_idx    = idx_q[top_p[SW-1:0]];
	assign top_val    = val_q[top_p[SW-1:0]];
	assign top_right  = right_q[top_p[SW-1:0]];
	assign sts.empty  = (ptr_q == '0);
	assign sts.single = (ptr_q == PW'(1));

endmodule

`default_nettype wire

### rtl/core/array_binary_tree_traversal_unit.sv
`default_nettype none

// Heap-ordered byte tree (children of slot i at 2i+1 and 2i+2, zero means empty) held in a
// synchronous store with one read and one write port that reset marks empty at once. A command
// is taken when start is high and busy is low. Set root, set left and set right hold busy high
// only through S_SET_CHK and put their single word on the ports in the cycle after it, so a new
// set command can be taken as that word appears. A traversal walks with an explicit stack: one
// S_WALK_CHK step per slot looked at (each live node and each empty or out-of-range child) and
// one S_WALK_RET step per return to a stacked node. Words appear one cycle each on status,
// node_value and last, marked by strobe; the receiver cannot stall them. A traversal gives at
// most fifteen node words, the final word of every command carries last.

module array_binary_tree_traversal_unit import abtt_pkg::*; #(
	parameter int NODE_COUNT = NODE_COUNT_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire logic [1:0] opcode,
	input  wire logic [7:0] value,
	input  wire logic [3:0] node_index,
	input  wire logic [1:0] order,
	output logic            strobe,
	output logic [2:0]      status,
	output logic [7:0]      node_value,
	output logic            last
);

	localparam int AW    = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
	localparam int CW0   = $clog2(2 * NODE_COUNT + 1);
	localparam int CW    = (CW0 > 5) ? CW0 : 5;
	localparam int STK_D = $clog2(NODE_COUNT + 1);

	state_t           state_q, state_d;
	op_t              op_q;
	ord_t             ord_q;
	logic [7:0]       val_q;
	logic [CW-1:0]    cur_q, cur_d;
	logic             inr_q, inr_d;
	logic [7:0]       pend_q, pend_d;
	logic             have_q, have_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;

	logic             strobe_q, strobe_d;
	status_t          status_q, status_d;
	logic [7:0]       nval_q, nval_d;
	logic             last_q, last_d;

	logic             accept;
	logic [AW-1:0]    raddr;
	logic [7:0]       rdata;
	logic             we;
	logic [AW-1:0]    waddr;
	logic             live;
	logic             cap_hit;
	logic             emit;
	logic [7:0]       emit_val;
	logic [CW-1:0]    set_child;
	logic [CW-1:0]    left_child;
	logic [CW-1:0]    right_child;

	stk_ctl_t         ctl;
	stk_sts_t         sts;
	logic [CW-1:0]    top_idx;
	logic [7:0]       top_val;
	logic             top_right;

	abtt_store #(
		.DEPTH (NODE_COUNT),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (we),
		.waddr (waddr),
		.wdata (val_q),
		.raddr (raddr),
		.rdata (rdata)
	);

	abtt_stack #(
		.DEPTH (STK_D),
		.IW    (CW)
	) u_stack (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.push_idx (cur_q),
		.push_val (rdata),
		.top_idx  (top_idx),
		.top_val  (top_val),
		.top_right(top_right),
		.sts      (sts)
	);

	assign busy        = (state_q != S_IDLE);
	assign accept      = start && !busy;
	assign live        = inr_q && is_letter(rdata);
	assign cap_hit     = (cnt_q == CNT_W'(RESULT_CAP - 1));
	assign set_child   = {cur_q[CW-2:0], 1'b0} + ((op_q == OP_LEFT) ? CW'(1) : CW'(2));
	assign left_child  = {cur_q[CW-2:0], 1'b0} + CW'(1);
	assign right_child = {top_idx[CW-2:0], 1'b0} + CW'(2);
	assign inr_d       = (cur_d < CW'(NODE_COUNT));
	assign raddr       = inr_d ? cur_d[AW-1:0] : '0;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (op_t'(opcode) != OP_TRAVERSE) begin
						state_d = S_SET_CHK;
					end else begin
						case (ord_t'(order))
							ORD_IN, ORD_PRE, ORD_POST: state_d = S_WALK_CHK;
							default:                   state_d = S_FLUSH;
						endcase
					end
				end
			end
			S_SET_CHK: begin
				state_d = S_IDLE;
			end
			S_WALK_CHK: begin
				if (live) begin
					if ((ord_q == ORD_PRE) && cap_hit) begin
						state_d = S_FLUSH;
					end
				end else if (sts.empty) begin
					state_d = S_FLUSH;
				end else begin
					state_d = S_WALK_RET;
				end
			end
			S_WALK_RET: begin
				if (!top_right) begin
					state_d = ((ord_q == ORD_IN) && cap_hit) ? S_FLUSH : S_WALK_CHK;
				end else if (((ord_q == ORD_POST) && cap_hit) || sts.single) begin
					state_d = S_FLUSH;
				end
			end
			S_FLUSH: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// datapath and result words
	always_comb begin
		cur_d    = cur_q;
		ctl      = '0;
		emit     = 1'b0;
		emit_val = rdata;
		we       = 1'b0;
		waddr    = '0;
		pend_d   = pend_q;
		have_d   = have_q;
		cnt_d    = cnt_q;
		strobe_d = 1'b0;
		status_d = ST_WRITTEN;
		nval_d   = 8'd0;
		last_d   = 1'b0;
		case (state_q)
			S_IDLE: begin
				cur_d = (op_t'(opcode) == OP_ROOT) ? '0 : CW'(node_index);
				if (accept) begin
					ctl.clear = 1'b1;
					have_d    = 1'b0;
					cnt_d     = '0;
				end
			end
			S_SET_CHK: begin
				strobe_d = 1'b1;
				last_d   = 1'b1;
				if (op_q == OP_ROOT) begin
					if (rdata != 8'd0) begin
						status_d = ST_ROOT_EXISTS;
					end else begin
						we = 1'b1;
					end
				end else if (!inr_q || (rdata == 8'd0)) begin
					status_d = ST_PARENT_EMPTY;
				end else if (set_child >= CW'(NODE_COUNT)) begin
					status_d = ST_CHILD_RANGE;
				end else begin
					we    = 1'b1;
					waddr = set_child[AW-1:0];
				end
			end
			S_WALK_CHK: begin
				if (live) begin
					ctl.push = 1'b1;
					emit     = (ord_q == ORD_PRE);
					cur_d    = left_child;
				end
			end
			S_WALK_RET: begin
				emit_val = top_val;
				if (!top_right) begin
					ctl.mark = 1'b1;
					emit     = (ord_q == ORD_IN);
					cur_d    = right_child;
				end else begin
					ctl.pop = 1'b1;
					emit    = (ord_q == ORD_POST);
				end
			end
			S_FLUSH: begin
				strobe_d = 1'b1;
				last_d   = 1'b1;
				if (have_q) begin
					status_d = ST_NODE;
					nval_d   = pend_q;
				end else begin
					status_d = ST_EMPTY;
				end
			end
			default: begin
				cur_d = cur_q;
			end
		endcase
		// a node word goes out once the next one is known, so last is settled
		if (emit) begin
			if (have_q) begin
				strobe_d = 1'b1;
				status_d = ST_NODE;
				nval_d   = pend_q;
			end
			pend_d = emit_val;
			have_d = 1'b1;
			cnt_d  = cnt_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			have_q   <= 1'b0;
			cnt_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			have_q   <= have_d;
			cnt_q    <= cnt_d;
			strobe_q <= strobe_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= op_t'(opcode);
			ord_q <= ord_t'(order);
			val_q <= value;
		end
		cur_q    <= cur_d;
		inr_q    <= inr_d;
		pend_q   <= pend_d;
		status_q <= status_d;
		nval_q   <= nval_d;
		last_q   <= last_d;
	end

	assign strobe     = strobe_q;
	assign status     = status_q;
	assign node_value = nval_q;
	assign last       = last_q;

`ifndef SYNTHESIS
	a_last_ends_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && last) |-> (state_q == S_IDLE))
		else $error("final word while command still running");

	a_single_word_last: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && (status_q != ST_NODE)) |-> last)
		else $error("non-node word without last");

	a_node_letter: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && (status_q == ST_NODE)) |-> is_letter(node_value))
		else $error("traversal word holds a non-letter");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("command accepted but block not busy");

	a_write_in_set: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (strobe_d && (status_d == ST_WRITTEN)))
		else $error("store written without a written word");
`endif

endmodule

`default_nettype wire
